[hw/rtl/multi_channel_debounce_queue_top_macros.svh]
// multi_channel_debounce_queue_top_macros.svh
// assertion macros used by the debounce queue checker
// no dependencies
`ifndef MULTI_CHANNEL_DEBOUNCE_QUEUE_TOP_MACROS_SVH
`define MULTI_CHANNEL_DEBOUNCE_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MCDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mcdq_pkg.sv]
// mcdq_pkg.sv
// types and constants of the multi-channel debounce queue
// no dependencies
package mcdq_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_CNT_W     = 5;
  localparam int CH_W          = 4;
  localparam int PIN_W         = 16;

  // configuration register indexes
  localparam logic [1:0] REG_ACCEPT_MASK      = 2'd0;
  localparam logic [1:0] REG_SETTLE_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_AGREE_MASK       = 2'd2;

  localparam logic [15:0] ACCEPT_MASK_RST      = 16'h2007;
  localparam logic [7:0]  SETTLE_THRESHOLD_RST = 8'd4;
  localparam logic [7:0]  AGREE_MASK_RST       = 8'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [7:0]      history;
    logic [7:0]      count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    entry_t next;
    logic   retire;
    logic   settled;
    logic   level;
  } upd_t;

endpackage

[hw/rtl/mcdq_ram.sv]
// mcdq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mcdq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mcdq_entry.sv]
// mcdq_entry.sv
// per-tick update of one queue entry: sample shift, count, retire decision
// depends on mcdq_pkg
module mcdq_entry (
  input  mcdq_pkg::entry_t            cur,
  input  logic [mcdq_pkg::PIN_W-1:0]  pin_levels,
  input  logic [7:0]                  settle_threshold,
  input  logic [7:0]                  agree_mask,
  output mcdq_pkg::upd_t              upd
);

  logic       pin_bit;
  logic [7:0] cnt_next;
  logic [7:0] hist_next;
  logic [7:0] agreed;
  logic       all_high;

  always_comb begin
    pin_bit   = pin_levels[cur.channel];
    cnt_next  = (cur.count == mcdq_pkg::COUNT_MAX) ? mcdq_pkg::COUNT_MAX : cur.count + 8'd1;
    hist_next = {cur.history[6:0], pin_bit};
    agreed    = hist_next & agree_mask;
    all_high  = (agreed == agree_mask);

    upd.next.channel = cur.channel;
    upd.next.history = hist_next;
    upd.next.count   = cnt_next;
    upd.retire       = (cnt_next > settle_threshold);
    upd.settled      = all_high || (agreed == 8'd0);
    upd.level        = all_high;
  end

endmodule

[hw/rtl/multi_channel_debounce_queue_top.sv]
// An ordered queue of armed channels kept in one entry memory (channel, sample history,
// sample count per slot) with a registered read. Every accepted arm or tick walks
// the queued entries oldest first, one memory read per cycle, and writes each entry back
// after updating it; busy stays high until the walk is through, and a new item is taken
// only while busy is low. An arm of a masked channel is dropped in the cycle it is taken.
// Retiring entries are removed and the survivors close up as they are written back.
// Results come out as one-cycle strobes on result_valid and cannot be held off; the
// final result of an item carries last_event. No clearing pass is needed after reset:
// only slots inside the queue are ever read.
module multi_channel_debounce_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [mcdq_pkg::CH_W-1:0]       channel,
  input  logic [mcdq_pkg::PIN_W-1:0]      pin_levels,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            result_valid,
  output logic [mcdq_pkg::CH_W-1:0]       event_channel,
  output logic                            settled_level,
  output logic                            is_settled,
  output logic                            overflow,
  output logic                            last_event
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;

  logic [15:0] accept_mask;
  logic [7:0]  settle_threshold;
  logic [7:0]  agree_mask;

  logic [AW-1:0] head;
  logic [LW-1:0] len;

  // latched item
  logic                       op_tick;
  logic [mcdq_pkg::CH_W-1:0]  op_channel;
  logic [mcdq_pkg::PIN_W-1:0] op_pins;

  // scan pointers
  logic [LW-1:0] scan_len;
  logic [LW-1:0] rpos;
  logic [AW-1:0] rslot;
  logic [AW-1:0] dslot;
  logic [AW-1:0] wslot;
  logic          pend;
  logic          surv_seen;
  logic          found;

  // one result held back until we know whether it is the last
  logic                      hold_valid;
  logic [mcdq_pkg::CH_W-1:0] hold_channel;
  logic                      hold_level;
  logic                      hold_settled;
  logic [mcdq_pkg::RES_CNT_W-1:0] nres;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [mcdq_pkg::ENTRY_W-1:0] ram_wdata;
  logic [mcdq_pkg::ENTRY_W-1:0] ram_rdata;
  mcdq_pkg::entry_t          rd_entry;
  mcdq_pkg::entry_t          fresh_entry;
  mcdq_pkg::upd_t            upd;

  logic          in_scan;
  logic          issue;
  logic          done;
  logic          ch_ok;
  logic          queue_full;
  logic          arm_hit;
  logic [LW:0]   app_sum;
  logic [AW-1:0] app_slot;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == AW'(QUEUE_DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  mcdq_ram #(
    .WIDTH (mcdq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rslot),
    .rdata (ram_rdata)
  );

  mcdq_entry u_entry (
    .cur              (rd_entry),
    .pin_levels       (op_pins),
    .settle_threshold (settle_threshold),
    .agree_mask       (agree_mask),
    .upd              (upd)
  );

  always_comb begin
    rd_entry    = mcdq_pkg::entry_t'(ram_rdata);
    fresh_entry = '{channel: op_channel, history: 8'd0, count: 8'd0};
    in_scan     = (state == S_SCAN);
    issue       = in_scan && (rpos < scan_len);
    done        = in_scan && !issue && !pend;
    ch_ok       = ({3'b000, channel} < 7'(mcdq_pkg::CHANNEL_COUNT)) && accept_mask[channel];
    queue_full  = (len == LW'(QUEUE_DEPTH));
    arm_hit     = pend && !op_tick && (rd_entry.channel == op_channel);
    app_sum     = (LW+1)'(head) + (LW+1)'(len);
    app_slot    = (app_sum >= (LW+1)'(QUEUE_DEPTH)) ? AW'(app_sum - (LW+1)'(QUEUE_DEPTH))
                                                     : AW'(app_sum);
    busy        = !(state == S_IDLE);
  end

  // write-back port: the slot written always trails the slot being read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wslot;
    ram_wdata = upd.next;
    if (pend && op_tick && !upd.retire) begin
      ram_we = 1'b1;
    end else if (arm_hit) begin
      ram_we    = 1'b1;
      ram_waddr = dslot;
      ram_wdata = fresh_entry;
    end else if (done && !op_tick && !found && !queue_full) begin
      ram_we    = 1'b1;
      ram_waddr = app_slot;
      ram_wdata = fresh_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_mask      <= mcdq_pkg::ACCEPT_MASK_RST;
      settle_threshold <= mcdq_pkg::SETTLE_THRESHOLD_RST;
      agree_mask       <= mcdq_pkg::AGREE_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mcdq_pkg::REG_ACCEPT_MASK:      accept_mask      <= cfg_data;
        mcdq_pkg::REG_SETTLE_THRESHOLD: settle_threshold <= cfg_data[7:0];
        mcdq_pkg::REG_AGREE_MASK:       agree_mask       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      len          <= '0;
      pend         <= 1'b0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && (action || ch_ok)) begin
            state      <= S_SCAN;
            op_tick    <= action;
            op_channel <= channel;
            op_pins    <= pin_levels;
            scan_len   <= len;
            rpos       <= '0;
            rslot      <= head;
            wslot      <= head;
            pend       <= 1'b0;
            surv_seen  <= 1'b0;
            found      <= 1'b0;
            hold_valid <= 1'b0;
            nres       <= '0;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            rpos  <= rpos + LW'(1);
            rslot <= slot_inc(rslot);
            dslot <= rslot;
          end
          if (pend && op_tick) begin
            if (upd.retire) begin
              len <= len - LW'(1);
              if (!surv_seen) begin
                // removal ahead of every survivor moves the head
                head  <= slot_inc(head);
                wslot <= slot_inc(wslot);
              end
              if (nres < mcdq_pkg::RES_CNT_W'(mcdq_pkg::MAX_RESULTS)) begin
                nres         <= nres + mcdq_pkg::RES_CNT_W'(1);
                hold_valid   <= 1'b1;
                hold_channel <= upd.next.channel;
                hold_level   <= upd.level;
                hold_settled <= upd.settled;
                if (hold_valid) begin
                  result_valid  <= 1'b1;
                  event_channel <= hold_channel;
                  settled_level <= hold_level;
                  is_settled    <= hold_settled;
                  overflow      <= 1'b0;
                  last_event    <= 1'b0;
                end
              end
            end else begin
              wslot     <= slot_inc(wslot);
              surv_seen <= 1'b1;
            end
          end
          if (arm_hit) begin
            found <= 1'b1;
          end
          if (done) begin
            state <= S_IDLE;
            if (op_tick) begin
              if (hold_valid) begin
                result_valid  <= 1'b1;
                event_channel <= hold_channel;
                settled_level <= hold_level;
                is_settled    <= hold_settled;
                overflow      <= 1'b0;
                last_event    <= 1'b1;
              end
            end else if (!found) begin
              if (queue_full) begin
                result_valid  <= 1'b1;
                event_channel <= op_channel;
                settled_level <= 1'b0;
                is_settled    <= 1'b0;
                overflow      <= 1'b1;
                last_event    <= 1'b1;
              end else begin
                len <= len + LW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/mcdq_checker.sv]
// mcdq_checker.sv
// port-level assertions for the debounce queue, bound to the top level
// depends on multi_channel_debounce_queue_top_macros.svh
`include "multi_channel_debounce_queue_top_macros.svh"

module mcdq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic settled_level,
  input logic is_settled,
  input logic overflow,
  input logic last_event
);

  // an overflow is the single, unsettled result of its arm
  `MCDQ_ASSERT_NOW(a_ovf_shape, clk, rst, result_valid && overflow, !is_settled && !settled_level && last_event, "overflow result malformed")

  // a bouncing channel reports no level
  `MCDQ_ASSERT_NOW(a_bounce_low, clk, rst, result_valid && !is_settled, !settled_level, "level set on unsettled result")

  // more results of the same item follow only while the scan still runs
  `MCDQ_ASSERT_NOW(a_more_busy, clk, rst, result_valid && !last_event, busy, "non-final result while idle")

  // nothing follows the final result
  `MCDQ_ASSERT_NEXT(a_last_gap, clk, rst, result_valid && last_event, !result_valid, "result after final item result")

  // a newly taken item cannot report in the very next cycle
  `MCDQ_ASSERT_NEXT(a_start_gap, clk, rst, start && !busy, !result_valid, "result right after item taken")

endmodule

bind multi_channel_debounce_queue_top mcdq_checker u_mcdq_checker (.*);
